[hw/rtl/i2c_register_access_master_assert.svh]
// Assertion macros for the I2C register access master.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CRAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define I2CRAM_ASSERT(lbl, prop, msg)
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/i2cram_pkg.sv]
// Shared types and constants of the I2C register access master.
// No dependencies; used by the interfaces, the sequencer and the top level.
`timescale 1ns / 1ps
package i2cram_pkg;

  typedef enum logic {
    REQ_TICK    = 1'b0,
    REQ_COMMAND = 1'b1
  } req_kind_e;

  localparam logic        READ_FLAG         = 1'b1;
  localparam logic [15:0] PHASE_LENGTH_RST  = 16'd1;

  typedef struct packed {
    logic       req_type;
    logic       is_read;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       missing_ack;
    logic       command_taken;
  } res_t;

endpackage

[hw/rtl/i2cram_if.sv]
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on i2cram_pkg for the payload types.
`timescale 1ns / 1ps
interface i2cram_req_if import i2cram_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cram_res_if import i2cram_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cram_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/i2cram_seq.sv]
// Bus sequencer: holds the transaction state and computes one result per request.
// Depends on i2cram_pkg.
`timescale 1ns / 1ps
module i2cram_seq import i2cram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  req_t        req_i,
  input  logic [15:0] phase_length_i,
  output res_t        res_o
);

  typedef enum logic [3:0] {
    StIdle    = 4'd0,
    StStart   = 4'd1,
    StAddrW   = 4'd2,
    StReg     = 4'd3,
    StData    = 4'd4,
    StRestart = 4'd5,
    StAddrR   = 4'd6,
    StRead    = 4'd7,
    StStop    = 4'd8
  } step_e;

  step_e       step_q, step_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  data_q, data_d;
  logic        kind_q, kind_d;
  logic [7:0]  rx_q, rx_d;
  logic        nack_q, nack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  function automatic logic is_byte_step(step_e s);
    return s inside {StAddrW, StReg, StData, StAddrR, StRead};
  endfunction

  // drive levels {scl, sda} after entering phase ph of step st
  function automatic logic [1:0] enter_phase(step_e st, logic [1:0] ph, logic [3:0] bc,
                                             logic [7:0] sh, logic [1:0] drv);
    logic scl, sda;
    scl = drv[1];
    sda = drv[0];
    case (st)
      StStart, StRestart: begin
        case (ph)
          2'd0: sda = 1'b1;
          2'd1: scl = 1'b1;
          2'd2: sda = 1'b0;
          default: scl = 1'b0;
        endcase
      end
      StStop: begin
        case (ph)
          2'd0: begin
            scl = 1'b0;
            sda = 1'b0;
          end
          2'd1: scl = 1'b1;
          2'd2: sda = 1'b1;
          default: ;
        endcase
      end
      StAddrW, StReg, StData, StAddrR, StRead: begin
        case (ph)
          2'd0: scl = 1'b0;
          // release SDA in read bits and in every acknowledge slot
          2'd1: sda = (st != StRead && !bc[3]) ? sh[~bc[2:0]] : 1'b1;
          2'd2: scl = 1'b1;
          default: scl = 1'b0;
        endcase
      end
      default: ;
    endcase
    return {scl, sda};
  endfunction

  function automatic logic [7:0] load_shift(step_e s, logic [7:0] sh, logic [6:0] addr,
                                            logic [7:0] rg, logic [7:0] dat);
    logic [7:0] r;
    case (s)
      StAddrW: r = {addr, 1'b0};
      StReg:   r = rg;
      StData:  r = dat;
      StAddrR: r = {addr, READ_FLAG};
      StRead:  r = 8'h00;
      default: r = sh;
    endcase
    return r;
  endfunction

  function automatic step_e next_step(step_e s, logic kind);
    step_e r;
    case (s)
      StStart:   r = StAddrW;
      StAddrW:   r = StReg;
      StReg:     r = kind ? StRestart : StData;
      StData:    r = StStop;
      StRestart: r = StAddrR;
      StAddrR:   r = StRead;
      StRead:    r = StStop;
      default:   r = StIdle;
    endcase
    return r;
  endfunction

  always_comb begin
    logic        busy;
    logic        done;
    logic        taken;
    logic        byte_step;
    logic [15:0] len;
    logic [1:0]  drv;
    step_e       nxt;

    step_d    = step_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    addr_d    = addr_q;
    reg_d     = reg_q;
    data_d    = data_q;
    kind_d    = kind_q;
    rx_d      = rx_q;
    nack_d    = nack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    done      = 1'b0;
    taken     = 1'b0;
    byte_step = 1'b0;
    drv       = {scl_q, sda_q};
    nxt       = StIdle;

    busy = (step_q >= StStart) && (step_q <= StStop);
    if (!busy) begin
      step_d  = StIdle;
      phase_d = 2'd0;
      bit_d   = 4'd0;
    end

    len = (phase_length_i == 16'd0) ? 16'd1 : phase_length_i;

    if (req_i.req_type == REQ_COMMAND) begin
      if (!busy) begin
        kind_d  = req_i.is_read;
        addr_d  = req_i.device_address;
        reg_d   = req_i.register_index;
        data_d  = req_i.write_data;
        nack_d  = 1'b0;
        tick_d  = 16'd0;
        step_d  = StStart;
        phase_d = 2'd0;
        bit_d   = 4'd0;
        drv     = enter_phase(StStart, 2'd0, 4'd0, shift_d, drv);
        taken   = 1'b1;
      end
    end else if (busy) begin
      tick_d = tick_q + 16'd1;
      if (tick_d >= len) begin
        tick_d    = 16'd0;
        byte_step = is_byte_step(step_q);
        // sample SDA at the end of the SCL-high phase
        if (byte_step && phase_q == 2'd2) begin
          if (!bit_q[3]) begin
            if (step_q == StRead) shift_d = {shift_q[6:0], req_i.sda_in};
          end else if (step_q != StRead && req_i.sda_in) begin
            nack_d = 1'b1;
          end
        end
        if (phase_q != 2'd3) begin
          phase_d = phase_q + 2'd1;
          drv     = enter_phase(step_q, phase_d, bit_q, shift_d, drv);
        end else begin
          phase_d = 2'd0;
          if (byte_step && !bit_q[3]) begin
            bit_d = bit_q + 4'd1;
            drv   = enter_phase(step_q, 2'd0, bit_d, shift_d, drv);
          end else begin
            nxt = next_step(step_q, kind_q);
            if (step_q == StRead) rx_d = shift_d;
            step_d  = nxt;
            bit_d   = 4'd0;
            shift_d = load_shift(nxt, shift_d, addr_q, reg_q, data_q);
            if (nxt == StIdle) begin
              done = 1'b1;
            end else begin
              drv = enter_phase(nxt, 2'd0, 4'd0, shift_d, drv);
            end
          end
        end
      end
    end

    scl_d = drv[1];
    sda_d = drv[0];

    res_o.scl_level     = scl_d;
    res_o.sda_level     = sda_d;
    res_o.busy_res      = (step_d != StIdle);
    res_o.done_res      = done;
    res_o.read_data     = rx_d;
    res_o.missing_ack   = nack_d;
    res_o.command_taken = taken;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StIdle;
      phase_q <= 2'd0;
      bit_q   <= 4'd0;
      tick_q  <= 16'd0;
      shift_q <= 8'h00;
      addr_q  <= 7'h00;
      reg_q   <= 8'h00;
      data_q  <= 8'h00;
      kind_q  <= 1'b0;
      rx_q    <= 8'h00;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (adv_i) begin
      step_q  <= step_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      kind_q  <= kind_d;
      rx_q    <= rx_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

[hw/rtl/i2c_register_access_master.sv]
// I2C register access master: one result per request, one request per cycle while results are taken.
// Each request passes through the input register, then its result through the result register;
// the sequencer state updates once per processed request.
// Throughput: one request per cycle while the result side takes results.
// Reset: asynchronous, active low; bus released (SCL and SDA high), idle, phase_length 1.
`timescale 1ns / 1ps
`include "i2c_register_access_master_assert.svh"
module i2c_register_access_master import i2cram_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i2cram_req_if.sink   req_i,
  i2cram_cfg_if.sink   cfg_i,
  i2cram_res_if.source res_o
);

  logic        in_vld_q, in_vld_d;
  req_t        in_q, in_d;
  logic        out_vld_q, out_vld_d;
  res_t        out_q, out_d;
  logic [15:0] phase_length_q, phase_length_d;
  logic        out_ok;
  logic        adv;
  logic        req_acc;
  res_t        res_d;
  logic        seq_done;
  logic        seq_taken;
  logic        bus_free;

  assign out_ok  = !out_vld_q || res_o.ready;
  assign adv     = in_vld_q && out_ok;
  assign req_acc = req_i.valid && req_i.ready;

  assign req_i.ready   = !in_vld_q || out_ok;
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  i2cram_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .req_i          (in_q),
    .phase_length_i (phase_length_q),
    .res_o          (res_d)
  );

  always_comb begin
    in_vld_d       = req_acc || (in_vld_q && !adv);
    in_d           = req_acc ? req_i.payload : in_q;
    out_vld_d      = adv || (out_vld_q && !res_o.ready);
    out_d          = adv ? res_d : out_q;
    phase_length_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.data : phase_length_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      phase_length_q <= PHASE_LENGTH_RST;
    end else begin
      in_vld_q       <= in_vld_d;
      out_vld_q      <= out_vld_d;
      phase_length_q <= phase_length_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign seq_done  = adv && res_d.done_res;
  assign seq_taken = adv && res_d.command_taken;
  assign bus_free  = res_d.scl_level && res_d.sda_level;

  // a finished transaction leaves the bus idle and released
  `I2CRAM_ASSERT(a_done_idle, seq_done |-> (!res_d.busy_res && bus_free), "done, bus held")
  // a started transaction begins from a released bus
  `I2CRAM_ASSERT(a_taken_start, seq_taken |-> (res_d.busy_res && bus_free && !res_d.missing_ack), "bad start")
  // a held request stays in the input register until it is processed
  `I2CRAM_ASSERT_NEXT(a_in_hold, (in_vld_q && !adv), in_vld_q, "pending request dropped")
  // a processed request always lands in the result register
  `I2CRAM_ASSERT_NEXT(a_out_load, adv, out_vld_q, "result lost")

endmodule
